/* rtl/balance_pid_with_feedforward_assert.svh */
`ifndef BALANCE_PID_WITH_FEEDFORWARD_ASSERT_SVH
`define BALANCE_PID_WITH_FEEDFORWARD_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bpf_pkg.sv */
package bpf_pkg;

  // field widths
  localparam int unsigned PitchWidth   = 16;
  localparam int unsigned CmdWidth     = 16;
  localparam int unsigned SpeedWidth   = 24;
  localparam int unsigned GainWidth    = 8;
  localparam int unsigned FfGainWidth  = 16;
  localparam int unsigned CfgDataWidth = 16;

  // internal widths
  localparam int unsigned ErrWidth     = 17;
  localparam int unsigned DiffWidth    = 18;
  localparam int unsigned SineWidth    = 16;
  localparam int unsigned FfWidth      = 21;
  localparam int unsigned TurnWidth    = 16;
  localparam int unsigned LinTermWidth = 19;
  localparam int unsigned AbsCmdWidth  = 17;

  // fixed-point constants
  localparam logic signed [30:0] InvTwoPiQ32  = 31'sd683565276;
  localparam logic signed [18:0] LinScaleQ16  = 19'sd249037;
  localparam logic [16:0]        TurnScaleQ16 = 17'd78643;
  localparam logic [16:0]        ErrLimitQ12  = 17'd6144;
  localparam int unsigned        IdxShift     = 44;
  localparam int unsigned        FfShift      = 11;

  localparam logic signed [SpeedWidth-1:0] SpeedMax = 24'sh7FFFFF;
  localparam logic signed [SpeedWidth-1:0] SpeedMin = 24'sh800000;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegKp = 2'd0,
    RegKi = 2'd1,
    RegKd = 2'd2,
    RegFf = 2'd3
  } bpf_reg_e;

  typedef struct packed {
    logic signed [GainWidth-1:0]   kp;
    logic signed [GainWidth-1:0]   ki;
    logic signed [GainWidth-1:0]   kd;
    logic signed [FfGainWidth-1:0] ff;
  } bpf_gains_t;

  localparam bpf_gains_t GainsReset = '{
    kp: -8'sd4,
    ki: -8'sd5,
    kd: -8'sd10,
    ff: 16'sd3840
  };

  // per-item mixing decision, carried down the pipeline
  typedef struct packed {
    logic window;   // 0 < |error| < 1.5
    logic clear;    // fallen outside the window
    logic ang_pos;
    logic ang_neg;
  } bpf_mode_t;

  // quarter-wave sine polynomial, Q15 in and out
  function automatic longint quarter_sine(input longint z);
    longint z2;
    longint r;
    z2 = (z * z) >>> 15;
    r  = 21167 - ((z2 * 2611) >>> 15);
    r  = 51472 - ((z2 * r) >>> 15);
    r  = (z * r) >>> 15;
    return (r > 32767) ? 64'sd32767 : r;
  endfunction

endpackage

/* rtl/bpf_if.sv */
interface bpf_item_if import bpf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [PitchWidth-1:0] pitch;
  logic signed [CmdWidth-1:0]   linear_cmd;
  logic signed [CmdWidth-1:0]   angular_cmd;
  logic                       fallen;

  modport source (output valid, pitch, linear_cmd, angular_cmd, fallen, input ready);
  modport sink   (input valid, pitch, linear_cmd, angular_cmd, fallen, output ready);
endinterface

interface bpf_result_if import bpf_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SpeedWidth-1:0] left_speed;
  logic signed [SpeedWidth-1:0] right_speed;

  modport source (output valid, left_speed, right_speed, input ready);
  modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

interface bpf_cfg_if import bpf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  bpf_reg_e                reg_index;
  logic [CfgDataWidth-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* rtl/bpf_cfg_regs.sv */
module bpf_cfg_regs import bpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpf_cfg_if.sink    cfg_i,
  output bpf_gains_t gains_o
);

  bpf_gains_t gains_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= GainsReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.reg_index)
        RegKp:   gains_q.kp <= cfg_i.wdata[GainWidth-1:0];
        RegKi:   gains_q.ki <= cfg_i.wdata[GainWidth-1:0];
        RegKd:   gains_q.kd <= cfg_i.wdata[GainWidth-1:0];
        RegFf:   gains_q.ff <= cfg_i.wdata[FfGainWidth-1:0];
        default: ;
      endcase
    end
  end

  assign gains_o = gains_q;

endmodule

/* rtl/bpf_sine_lut.sv */
module bpf_sine_lut import bpf_pkg::*; #(
  parameter  int unsigned SineDepth = 256,
  localparam int unsigned AddrWidth = $clog2(SineDepth),
  localparam int unsigned KWidth    = AddrWidth + 2
) (
  input  logic signed [KWidth-1:0]    k_raw_i,
  output logic signed [SineWidth-1:0] sine_o
);

  typedef logic signed [SineWidth-1:0] lut_t [SineDepth];

  // full-wave table built from the quarter-wave polynomial
  function automatic lut_t build_lut();
    lut_t   t;
    longint quad;
    longint rem;
    longint z;
    longint s;
    for (int k = 0; k < SineDepth; k++) begin
      quad = (4 * longint'(k)) / SineDepth;
      rem  = 4 * longint'(k) - quad * SineDepth;
      z    = (rem * 32768) / SineDepth;
      if (quad[0]) begin
        z = 32768 - z;
      end
      s = quarter_sine(z);
      if (quad >= 2) begin
        s = -s;
      end
      t[k] = SineWidth'(s);
    end
    return t;
  endfunction

  localparam lut_t SineLut = build_lut();
  localparam logic signed [KWidth:0] DepthK = (KWidth + 1)'(SineDepth);

  logic signed [KWidth:0]  k_ext;
  logic signed [KWidth:0]  k_one;
  logic signed [KWidth:0]  k_two;
  logic [AddrWidth-1:0]    addr;

  // raw index lies within two table lengths of zero, so two folds suffice
  always_comb begin
    k_ext = {k_raw_i[KWidth-1], k_raw_i};
    k_one = k_ext[KWidth] ? k_ext + DepthK : k_ext;
    if (k_one[KWidth]) begin
      k_two = k_one + DepthK;
    end else if (k_one >= DepthK) begin
      k_two = k_one - DepthK;
    end else begin
      k_two = k_one;
    end
  end

  assign addr   = k_two[AddrWidth-1:0];
  assign sine_o = SineLut[addr];

endmodule

/* rtl/bpf_mix_sat.sv */
module bpf_mix_sat import bpf_pkg::*; #(
  parameter int unsigned SumWidth = 36
) (
  input  logic signed [SumWidth-1:0]   pid_sum_i,
  input  logic signed [FfWidth-1:0]    ff_i,
  input  logic [TurnWidth-1:0]         turn_i,
  input  bpf_mode_t                    mode_i,
  output logic signed [SpeedWidth-1:0] left_o,
  output logic signed [SpeedWidth-1:0] right_o
);

  function automatic logic signed [SpeedWidth-1:0] sat_speed(
    input logic signed [SumWidth-1:0] v
  );
    logic [SumWidth-SpeedWidth:0] top_bits;
    top_bits = v[SumWidth-1:SpeedWidth-1];
    if ((&top_bits) || !(|top_bits)) begin
      return v[SpeedWidth-1:0];
    end else if (v[SumWidth-1]) begin
      return SpeedMin;
    end else begin
      return SpeedMax;
    end
  endfunction

  logic signed [SumWidth-1:0] drive;
  logic signed [SumWidth-1:0] turn_ext;
  logic signed [SumWidth-1:0] left_raw;
  logic signed [SumWidth-1:0] right_raw;

  assign drive    = pid_sum_i + SumWidth'(ff_i);
  assign turn_ext = SumWidth'({1'b0, turn_i});

  always_comb begin
    left_raw  = drive;
    right_raw = drive;
    if (mode_i.window) begin
      if (mode_i.ang_pos) begin
        left_raw  = drive - turn_ext;
        right_raw = drive + turn_ext;
      end else if (mode_i.ang_neg) begin
        left_raw  = drive + turn_ext;
        right_raw = drive - turn_ext;
      end
    end else if (mode_i.clear) begin
      left_raw  = '0;
      right_raw = '0;
    end
  end

  assign left_o  = sat_speed(left_raw);
  assign right_o = sat_speed(right_raw);

endmodule

/* rtl/balance_pid_with_feedforward.sv */
// channel    dir   transfer when         payload
// cfg_i      in    valid && ready        reg_index, wdata (ready held high)
// item_i     in    valid && ready        pitch, linear_cmd, angular_cmd, fallen
// result_o   out   valid && ready        left_speed, right_speed
//
// one item per cycle sustained while result_o.ready stays high
// the pipeline is the five stages plus the output register, its depth set by the
// pitch-to-index multipliers, the sine table and the feedforward multiplier
// reset clears all valid bits, the integral and the previous error, and returns
// the gains to their reset values
// a stalled result_o first absorbs empty stages; item_i.ready drops only when
// every stage holds an item

`include "balance_pid_with_feedforward_assert.svh"

module balance_pid_with_feedforward import bpf_pkg::*; #(
  parameter int unsigned SineDepth     = 256,
  parameter int unsigned IntegralWidth = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpf_cfg_if.sink       cfg_i,
  bpf_item_if.sink      item_i,
  bpf_result_if.source  result_o
);

  // derived widths
  localparam int unsigned SumWidth   = IntegralWidth + 12;
  localparam int unsigned ProdPWidth = PitchWidth + 31;
  localparam int unsigned DepthWidth = $clog2(SineDepth + 1) + 1;
  localparam int unsigned QWidth     = ProdPWidth + DepthWidth;
  localparam int unsigned KWidth     = $clog2(SineDepth) + 2;
  localparam int unsigned ITermWidth = IntegralWidth + GainWidth;
  localparam int unsigned PTermWidth = ErrWidth + GainWidth;
  localparam int unsigned DTermWidth = DiffWidth + GainWidth;

  localparam logic signed [DepthWidth-1:0] DepthS = DepthWidth'(SineDepth);
  localparam logic signed [QWidth-1:0]     RoundQ = QWidth'(1) << (IdxShift - 1);

  localparam logic signed [IntegralWidth-1:0] IntegMax = {1'b0, {(IntegralWidth-1){1'b1}}};
  localparam logic signed [IntegralWidth-1:0] IntegMin = {1'b1, {(IntegralWidth-1){1'b0}}};

  // configuration
  bpf_gains_t gains;

  bpf_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .gains_o (gains)
  );

  // pipeline flow control: a stage loads when empty or when the next one loads
  logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_o;
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, o_v_q;

  assign ld_o = !o_v_q || result_o.ready;
  assign ld_e = !e_v_q || ld_o;
  assign ld_d = !d_v_q || ld_e;
  assign ld_c = !c_v_q || ld_d;
  assign ld_b = !b_v_q || ld_c;
  assign ld_a = !a_v_q || ld_b;

  assign item_i.ready = ld_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (ld_a) a_v_q <= item_i.valid;
      if (ld_b) b_v_q <= a_v_q;
      if (ld_c) c_v_q <= b_v_q;
      if (ld_d) d_v_q <= c_v_q;
      if (ld_e) e_v_q <= d_v_q;
      if (ld_o) o_v_q <= e_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: input register, error, integral, difference, mode, pitch scaling
  // ---------------------------------------------------------------------------
  logic signed [PitchWidth-1:0] a_pitch_q;
  logic signed [CmdWidth-1:0]   a_lin_q;
  logic signed [CmdWidth-1:0]   a_ang_q;
  logic                         a_fallen_q;

  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      a_pitch_q  <= item_i.pitch;
      a_lin_q    <= item_i.linear_cmd;
      a_ang_q    <= item_i.angular_cmd;
      a_fallen_q <= item_i.fallen;
    end
  end

  logic signed [IntegralWidth-1:0] integral_q;
  logic signed [ErrWidth-1:0]      prev_q;

  logic signed [ErrWidth-1:0]      a_err;
  logic [ErrWidth-1:0]             a_mag;
  logic signed [IntegralWidth:0]   a_sum;
  logic signed [IntegralWidth-1:0] a_integ;
  logic signed [DiffWidth-1:0]     a_diff;
  logic signed [ProdPWidth-1:0]    a_p;
  bpf_mode_t                       a_mode;

  // error is the negated pitch, one bit wider so full-scale pitch stays exact
  assign a_err = -{a_pitch_q[PitchWidth-1], a_pitch_q};
  assign a_mag = a_err[ErrWidth-1] ? ErrWidth'(-a_err) : a_err;

  // saturating integral: overflow shows as a mismatch of the two top bits
  assign a_sum   = {integral_q[IntegralWidth-1], integral_q} + (IntegralWidth + 1)'(a_err);
  assign a_integ = (a_sum[IntegralWidth] != a_sum[IntegralWidth-1])
                   ? (a_sum[IntegralWidth] ? IntegMin : IntegMax)
                   : a_sum[IntegralWidth-1:0];
  assign a_diff  = {a_err[ErrWidth-1], a_err} - {prev_q[ErrWidth-1], prev_q};

  // pitch times 1/(2*pi) in Q32; the table depth multiply follows in stage b
  assign a_p = a_pitch_q * InvTwoPiQ32;

  always_comb begin
    a_mode.window  = (a_err != '0) && (a_mag < ErrLimitQ12);
    a_mode.clear   = !a_mode.window && a_fallen_q;
    a_mode.ang_pos = !a_ang_q[CmdWidth-1] && (a_ang_q != '0);
    a_mode.ang_neg = a_ang_q[CmdWidth-1];
  end

  // controller state moves on when the item leaves stage a, so the next item
  // in stage a already sees it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      prev_q     <= '0;
    end else if (a_v_q && ld_b) begin
      if (a_mode.clear) begin
        integral_q <= '0;
        prev_q     <= '0;
      end else begin
        integral_q <= a_integ;
        prev_q     <= a_err;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: gain products, forward term, turn magnitude, sine index
  // ---------------------------------------------------------------------------
  logic signed [ErrWidth-1:0]      b_err_q;
  logic signed [DiffWidth-1:0]     b_diff_q;
  logic signed [IntegralWidth-1:0] b_integ_q;
  logic signed [ProdPWidth-1:0]    b_p_q;
  logic signed [CmdWidth-1:0]      b_lin_q;
  logic signed [CmdWidth-1:0]      b_ang_q;
  bpf_mode_t                       b_mode_q;

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      b_err_q   <= a_err;
      b_diff_q  <= a_diff;
      b_integ_q <= a_integ;
      b_p_q     <= a_p;
      b_lin_q   <= a_lin_q;
      b_ang_q   <= a_ang_q;
      b_mode_q  <= a_mode;
    end
  end

  logic signed [QWidth-1:0]           b_q;
  logic signed [QWidth-1:0]           b_qr;
  logic signed [KWidth-1:0]           b_kraw;
  logic signed [PTermWidth-1:0]       b_pterm;
  logic signed [ITermWidth-1:0]       b_iterm;
  logic signed [DTermWidth-1:0]       b_dterm;
  logic signed [CmdWidth+18:0]        b_lprod;
  logic signed [LinTermWidth-1:0]     b_lterm;
  logic signed [AbsCmdWidth-1:0]      b_ang_ext;
  logic [AbsCmdWidth-1:0]             b_amag;
  logic [2*AbsCmdWidth-1:0]           b_tprod;
  logic [TurnWidth-1:0]               b_turn;

  // round-half-up then floor shift gives the signed table index
  assign b_q    = b_p_q * DepthS;
  assign b_qr   = b_q + RoundQ;
  assign b_kraw = b_qr[IdxShift+KWidth-1:IdxShift];

  assign b_pterm = gains.kp * b_err_q;
  assign b_iterm = gains.ki * b_integ_q;
  assign b_dterm = gains.kd * b_diff_q;

  // forward command times 3.8, floored
  assign b_lprod = b_lin_q * LinScaleQ16;
  assign b_lterm = b_lprod[CmdWidth+18:16];

  // turn magnitude times 1.2, rounded
  assign b_ang_ext = {b_ang_q[CmdWidth-1], b_ang_q};
  assign b_amag    = b_ang_ext[AbsCmdWidth-1] ? AbsCmdWidth'(-b_ang_ext) : b_ang_ext;
  assign b_tprod   = b_amag * TurnScaleQ16 + (2*AbsCmdWidth)'(32768);
  assign b_turn    = b_tprod[TurnWidth+15:16];

  // ---------------------------------------------------------------------------
  // stage c: sine table read and sum of the gain terms
  // ---------------------------------------------------------------------------
  logic signed [KWidth-1:0]       c_kraw_q;
  logic signed [PTermWidth-1:0]   c_pterm_q;
  logic signed [ITermWidth-1:0]   c_iterm_q;
  logic signed [DTermWidth-1:0]   c_dterm_q;
  logic signed [LinTermWidth-1:0] c_lterm_q;
  logic [TurnWidth-1:0]           c_turn_q;
  bpf_mode_t                      c_mode_q;

  always_ff @(posedge clk_i) begin
    if (ld_c) begin
      c_kraw_q  <= b_kraw;
      c_pterm_q <= b_pterm;
      c_iterm_q <= b_iterm;
      c_dterm_q <= b_dterm;
      c_lterm_q <= b_lterm;
      c_turn_q  <= b_turn;
      c_mode_q  <= b_mode_q;
    end
  end

  logic signed [SineWidth-1:0] c_sine;
  logic signed [SumWidth-1:0]  c_sum;

  bpf_sine_lut #(
    .SineDepth (SineDepth)
  ) u_sine_lut (
    .k_raw_i (c_kraw_q),
    .sine_o  (c_sine)
  );

  assign c_sum = SumWidth'(c_pterm_q) + SumWidth'(c_iterm_q)
               + SumWidth'(c_dterm_q) + SumWidth'(c_lterm_q);

  // ---------------------------------------------------------------------------
  // stage d: feedforward gain times sine, Q8.8 by Q1.15 down to Q.12
  // ---------------------------------------------------------------------------
  logic signed [SineWidth-1:0] d_sine_q;
  logic signed [SumWidth-1:0]  d_sum_q;
  logic [TurnWidth-1:0]        d_turn_q;
  bpf_mode_t                   d_mode_q;

  always_ff @(posedge clk_i) begin
    if (ld_d) begin
      d_sine_q <= c_sine;
      d_sum_q  <= c_sum;
      d_turn_q <= c_turn_q;
      d_mode_q <= c_mode_q;
    end
  end

  logic signed [FfGainWidth+SineWidth-1:0] d_ffprod;
  logic signed [FfWidth-1:0]               d_ff;

  assign d_ffprod = gains.ff * d_sine_q;
  assign d_ff     = d_ffprod[FfGainWidth+SineWidth-1:FfShift];

  // ---------------------------------------------------------------------------
  // stage e: drive, wheel split and saturation
  // ---------------------------------------------------------------------------
  logic signed [SumWidth-1:0] e_sum_q;
  logic signed [FfWidth-1:0]  e_ff_q;
  logic [TurnWidth-1:0]       e_turn_q;
  bpf_mode_t                  e_mode_q;

  always_ff @(posedge clk_i) begin
    if (ld_e) begin
      e_sum_q  <= d_sum_q;
      e_ff_q   <= d_ff;
      e_turn_q <= d_turn_q;
      e_mode_q <= d_mode_q;
    end
  end

  logic signed [SpeedWidth-1:0] mix_left;
  logic signed [SpeedWidth-1:0] mix_right;

  bpf_mix_sat #(
    .SumWidth (SumWidth)
  ) u_mix_sat (
    .pid_sum_i (e_sum_q),
    .ff_i      (e_ff_q),
    .turn_i    (e_turn_q),
    .mode_i    (e_mode_q),
    .left_o    (mix_left),
    .right_o   (mix_right)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic signed [SpeedWidth-1:0] o_left_q;
  logic signed [SpeedWidth-1:0] o_right_q;

  always_ff @(posedge clk_i) begin
    if (ld_o) begin
      o_left_q  <= mix_left;
      o_right_q <= mix_right;
    end
  end

  assign result_o.valid       = o_v_q;
  assign result_o.left_speed  = o_left_q;
  assign result_o.right_speed = o_right_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `BPF_ASSERT_NXT(accept_fills_a_chk, item_i.valid && item_i.ready, a_v_q,
                  "accepted item did not reach stage a")
  `BPF_ASSERT_NXT(clear_state_chk, a_v_q && ld_b && a_mode.clear,
                  integral_q == '0 && prev_q == '0,
                  "fallen item did not clear controller state")
  `BPF_ASSERT_NXT(prev_err_chk, a_v_q && ld_b && !a_mode.clear, prev_q == $past(a_err),
                  "previous error not taken from departing item")
  `BPF_ASSERT_IMP(equal_wheels_chk, e_v_q && !e_mode_q.window && !e_mode_q.clear,
                  mix_left == mix_right, "wheels differ outside the window")
  `BPF_ASSERT_IMP(fallen_zero_chk, e_v_q && e_mode_q.clear,
                  mix_left == '0 && mix_right == '0, "fallen item gave non-zero speed")

endmodule

/* tb/balance_pid_with_feedforward_test.sv */
`timescale 1ns / 100ps

module balance_pid_with_feedforward_test import bpf_pkg::*; ();

  // block configuration, kept equal to the instance below
  localparam int SineDepth     = 256;
  localparam int IntegralWidth = 24;

  // pipeline depth plus the output register, with a little margin
  localparam int DrainCycles = 10;

  localparam longint IntegMax = (longint'(1) <<< (IntegralWidth - 1)) - 1;
  localparam longint IntegMin = -(longint'(1) <<< (IntegralWidth - 1));

  typedef struct packed {
    logic signed [SpeedWidth-1:0] left;
    logic signed [SpeedWidth-1:0] right;
  } wheel_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpf_cfg_if    cfg_bus ();
  bpf_item_if   sample_bus ();
  bpf_result_if wheel_bus ();

  balance_pid_with_feedforward #(
    .SineDepth     (SineDepth),
    .IntegralWidth (IntegralWidth)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .item_i   (sample_bus),
    .result_o (wheel_bus)
  );

  always #5 clk_i = ~clk_i;

  // predicted wheel speeds, oldest first
  wheel_pair_t wheel_expect_q[$];

  // our own copy of the controller state and gains
  bpf_gains_t gains_model;
  longint     integ_acc;
  longint     prev_err;

  int fault_count = 0;

  // when set, neither side inserts idle cycles
  bit quiet_mode = 1'b0;

  // idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Q1.15 sine from the table index the block derives from pitch
  function automatic longint table_sine(input longint pitch);
    longint t;
    longint k;
    longint quad;
    longint rem;
    longint z;
    longint z2;
    longint r;
    // index = round(pitch * depth / 2pi), ties up, wrapped into the table
    t = pitch * (longint'(SineDepth) * longint'(InvTwoPiQ32))
        + (longint'(1) <<< (IdxShift - 1));
    k = (t >>> IdxShift) % SineDepth;
    if (k < 0) k += SineDepth;
    // quarter-wave symmetry
    quad = (4 * k) / SineDepth;
    rem  = 4 * k - quad * SineDepth;
    z    = (rem * 32768) / SineDepth;
    if (quad[0]) z = 32768 - z;
    // odd polynomial in Q15
    z2 = (z * z) >>> 15;
    r  = 21167 - ((z2 * 2611) >>> 15);
    r  = 51472 - ((z2 * r) >>> 15);
    r  = (z * r) >>> 15;
    if (r > 32767) r = 32767;
    return (quad >= 2) ? -r : r;
  endfunction

  // one control step: updates the state copy and queues the wheel pair
  task automatic predict_wheels(input logic signed [PitchWidth-1:0] pitch,
                                input logic signed [CmdWidth-1:0] lin,
                                input logic signed [CmdWidth-1:0] ang,
                                input logic fallen);
    longint err;
    longint diff;
    longint ff_term;
    longint drive;
    longint aerr;
    longint aang;
    longint turn;
    longint lw;
    longint rw;
    wheel_pair_t w;
    err       = -longint'(pitch);
    integ_acc = clamp_to(integ_acc + err, IntegMin, IntegMax);
    diff      = err - prev_err;
    prev_err  = err;

    ff_term = (longint'($signed(gains_model.ff)) * table_sine(longint'(pitch))) >>> FfShift;
    drive   = ((longint'(lin) * longint'(LinScaleQ16)) >>> 16)
            + longint'($signed(gains_model.kp)) * err
            + longint'($signed(gains_model.ki)) * integ_acc
            + longint'($signed(gains_model.kd)) * diff
            + ff_term;

    aerr = (err < 0) ? -err : err;
    if (aerr > 0 && aerr < longint'(ErrLimitQ12)) begin
      // inside the window the turn command splits the wheels, fallen or not
      aang = (ang < 0) ? -longint'(ang) : longint'(ang);
      turn = (aang * longint'(TurnScaleQ16) + 32768) >>> 16;
      if (ang > 0) begin
        lw = drive - turn;
        rw = drive + turn;
      end else if (ang < 0) begin
        lw = drive + turn;
        rw = drive - turn;
      end else begin
        lw = drive;
        rw = drive;
      end
    end else if (fallen) begin
      integ_acc = 0;
      prev_err  = 0;
      lw = 0;
      rw = 0;
    end else begin
      lw = drive;
      rw = drive;
    end
    w.left  = SpeedWidth'(clamp_to(lw, longint'(SpeedMin), longint'(SpeedMax)));
    w.right = SpeedWidth'(clamp_to(rw, longint'(SpeedMin), longint'(SpeedMax)));
    wheel_expect_q.push_back(w);
  endtask

  // one sample transfer; valid stays high when the next sample follows at once
  task automatic send_sample(input logic signed [PitchWidth-1:0] pitch,
                             input logic signed [CmdWidth-1:0] lin,
                             input logic signed [CmdWidth-1:0] ang,
                             input logic fallen);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_bus.valid       <= 1'b1;
    sample_bus.pitch       <= pitch;
    sample_bus.linear_cmd  <= lin;
    sample_bus.angular_cmd <= ang;
    sample_bus.fallen      <= fallen;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    predict_wheels(pitch, lin, ang, fallen);
  endtask

  // random sample, weighted towards the balancing window where turning matters
  task automatic send_random_sample();
    logic signed [PitchWidth-1:0] pitch;
    logic signed [CmdWidth-1:0]   lin;
    logic signed [CmdWidth-1:0]   ang;
    logic                         fallen;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: pitch = PitchWidth'($urandom_range(0, 12286) - 6143);
      5:             pitch = PitchWidth'($urandom_range(0, 128) - 64);
      6: begin
        case ($urandom_range(0, 5))
          0:       pitch = 16'sh8000;
          1:       pitch = 16'sh7FFF;
          2:       pitch = '0;
          3:       pitch = 16'sd6144;
          4:       pitch = -16'sd6144;
          default: pitch = 16'sd6143;
        endcase
      end
      default:       pitch = PitchWidth'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       lin = 16'sh8000;
      1:       lin = 16'sh7FFF;
      default: lin = CmdWidth'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       ang = '0;
      1:       ang = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
      default: ang = CmdWidth'($urandom);
    endcase
    fallen = ($urandom_range(0, 7) == 0);
    send_sample(pitch, lin, ang, fallen);
  endtask

  // stop sending and wait until the pipeline is empty
  task automatic settle_block();
    sample_bus.valid <= 1'b0;
    while (wheel_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all four gain registers back to back, junk in unused upper bits
  task automatic set_gains(input bpf_gains_t g);
    bpf_reg_e                idx;
    logic [7:0]              pad;
    logic [CfgDataWidth-1:0] word;
    settle_block();
    idx = RegKp;
    repeat (4) begin
      pad = 8'($urandom);
      case (idx)
        RegKp:   word = {pad, g.kp};
        RegKi:   word = {pad, g.ki};
        RegKd:   word = {pad, g.kd};
        default: word = g.ff;
      endcase
      cfg_bus.valid     <= 1'b1;
      cfg_bus.reg_index <= idx;
      cfg_bus.wdata     <= word;
      @(posedge clk_i);
      while (!cfg_bus.ready) @(posedge clk_i);
      idx = idx.next();
    end
    cfg_bus.valid <= 1'b0;
    gains_model = g;
  endtask

  // directed samples against the gains left by reset
  task automatic test_reset_gains();
    send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);           // zero error, upright
    send_sample(16'sd0, 16'sd4096, 16'sd4096, 1'b1);     // zero error, fallen clears
    send_sample(16'sd100, 16'sd4096, 16'sd4096, 1'b0);   // right wheel gets more
    send_sample(-16'sd100, 16'sd0, -16'sd4096, 1'b0);    // left wheel gets more
    send_sample(16'sd2000, -16'sd4096, 16'sd0, 1'b0);    // no turn in window
    send_sample(16'sd3000, 16'sd1000, 16'sd1000, 1'b1);  // fallen ignored in window
    send_sample(16'sd6143, 16'sd0, 16'sh7FFF, 1'b0);     // window edge, full turn
    send_sample(-16'sd6143, 16'sd0, 16'sh8000, 1'b1);    // window edge, most negative turn
    send_sample(16'sd6144, 16'sd0, 16'sd2000, 1'b0);     // just outside window
    send_sample(-16'sd6144, 16'sd0, 16'sd2000, 1'b1);    // just outside, fallen
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);  // largest error magnitude
    send_sample(16'sh8000, 16'sh7FFF, 16'sd0, 1'b1);
    send_sample(16'sd1, -16'sd1, 16'sd1, 1'b0);
    send_sample(-16'sd1, 16'sd1, -16'sd1, 1'b0);
    send_sample(16'sd12868, 16'sd0, 16'sd0, 1'b0);       // near pi
    send_sample(-16'sd25736, 16'sd0, 16'sd0, 1'b0);      // near minus two pi
    send_sample(16'sd6434, 16'sd0, 16'sd0, 1'b0);        // near pi over two
    send_sample(16'sd16000, 16'sd0, 16'sh8000, 1'b0);    // turn unused outside window
  endtask

  // every gain at its extremes and at zero
  task automatic test_gain_extremes();
    set_gains('{kp: 8'sd127, ki: 8'sd127, kd: 8'sd127, ff: 16'sh7FFF});
    repeat (40) send_random_sample();
    set_gains('{kp: -8'sd128, ki: -8'sd128, kd: -8'sd128, ff: 16'sh8000});
    repeat (40) send_random_sample();
    set_gains('{kp: 8'sd0, ki: 8'sd0, kd: 8'sd0, ff: 16'sd0});
    repeat (20) send_random_sample();
    set_gains('{kp: 8'sd127, ki: -8'sd128, kd: 8'sd0, ff: 16'sh8000});
    repeat (20) send_random_sample();
  endtask

  // drive the integral into both limits, with a fallen clear between
  task automatic test_integral_saturation();
    set_gains('{kp: 8'sd0, ki: 8'sd1, kd: 8'sd0, ff: 16'sd256});
    repeat (270) send_sample(16'sh8000, CmdWidth'($urandom), CmdWidth'($urandom), 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
    repeat (270) send_sample(16'sh7FFF, CmdWidth'($urandom), CmdWidth'($urandom), 1'b0);
  endtask

  // random gains, one phase run with both sides flat out
  task automatic test_random_gains();
    bpf_gains_t g;
    for (int phase = 0; phase < 4; phase++) begin
      g.kp = GainWidth'($urandom);
      g.ki = GainWidth'($urandom);
      g.kd = GainWidth'($urandom);
      g.ff = FfGainWidth'($urandom);
      set_gains(g);
      quiet_mode = (phase == 2);
      repeat (150) send_random_sample();
    end
    quiet_mode = 1'b0;
  endtask

  // result sink: bursts of ready with random stalls between them
  initial begin : wheel_sink
    int run;
    int gap;
    wheel_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run = $urandom_range(1, 24);
      wheel_bus.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        wheel_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin
    wheel_pair_t w;
    if (rst_ni && wheel_bus.valid && wheel_bus.ready) begin
      if (wheel_expect_q.size() == 0) begin
        $error("wheel speed transfer with no prediction waiting: left %0d right %0d",
               wheel_bus.left_speed, wheel_bus.right_speed);
        fault_count++;
      end else begin
        w = wheel_expect_q.pop_front();
        if (wheel_bus.left_speed !== w.left) begin
          $error("left_speed mismatch: expected %0d, got %0d", w.left, wheel_bus.left_speed);
          fault_count++;
        end
        if (wheel_bus.right_speed !== w.right) begin
          $error("right_speed mismatch: expected %0d, got %0d", w.right,
                 wheel_bus.right_speed);
          fault_count++;
        end
      end
    end
  end

  // main sequence
  initial begin : run_tests
    sample_bus.valid       = 1'b0;
    sample_bus.pitch       = '0;
    sample_bus.linear_cmd  = '0;
    sample_bus.angular_cmd = '0;
    sample_bus.fallen      = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.reg_index      = RegKp;
    cfg_bus.wdata          = '0;
    rst_ni                 = 1'b0;

    gains_model = GainsReset;
    integ_acc   = 0;
    prev_err    = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_gains();
    test_gain_extremes();
    test_integral_saturation();
    test_random_gains();

    settle_block();
    if (fault_count == 0 && wheel_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
